// ===== src/tsc_pkg.sv =====
// package: shared types, constants and helpers of the time record stream checker
`timescale 1ns / 1ps
package tsc_pkg;

    // record layout
    localparam int unsigned RECORD_BYTES = 22;
    localparam int unsigned POS_W        = $clog2(RECORD_BYTES);

    localparam logic [POS_W-1:0] POS_START  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_DAY    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_COLON0 = POS_W'(4);
    localparam logic [POS_W-1:0] POS_HOUR   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_COLON1 = POS_W'(7);
    localparam logic [POS_W-1:0] POS_MINUTE = POS_W'(8);
    localparam logic [POS_W-1:0] POS_COLON2 = POS_W'(10);
    localparam logic [POS_W-1:0] POS_SECOND = POS_W'(11);
    localparam logic [POS_W-1:0] POS_QUAL   = POS_W'(13);
    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(RECORD_BYTES - 1);

    // byte codes
    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // time limits and scale factors
    localparam logic [6:0]  HOUR_MAX     = 7'd24;
    localparam logic [6:0]  MINSEC_MAX   = 7'd59;
    localparam int unsigned SECS_W       = 27;
    localparam logic [SECS_W-1:0] SECS_PER_DAY  = SECS_W'(86400);
    localparam logic [SECS_W-1:0] SECS_PER_HOUR = SECS_W'(3600);
    localparam logic [SECS_W-1:0] SECS_PER_MIN  = SECS_W'(60);

    // digit flag bits
    localparam int unsigned FD_DAY    = 0;
    localparam int unsigned FD_HOUR   = 1;
    localparam int unsigned FD_MINUTE = 2;
    localparam int unsigned FD_SECOND = 3;

    // register reset values
    localparam logic [63:0] EXP_STEP_RESET = 64'd20000000;
    localparam logic [15:0] WARMUP_RESET   = 16'd20;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_WARN_DEGRADED  = 2'd0,
        CFG_EXPECTED_STEP  = 2'd1,
        CFG_WARMUP_RECORDS = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        QUAL_SPACE   = 3'd0,
        QUAL_DOT     = 3'd1,
        QUAL_STAR    = 3'd2,
        QUAL_HASH    = 3'd3,
        QUAL_QUEST   = 3'd4,
        QUAL_INVALID = 3'd5
    } quality_t;

    typedef enum logic [2:0] {
        TERR_OK          = 3'd0,
        TERR_DAY_DIGIT   = 3'd1,
        TERR_HOUR_DIGIT  = 3'd2,
        TERR_HOUR_RANGE  = 3'd3,
        TERR_MIN_DIGIT   = 3'd4,
        TERR_MIN_RANGE   = 3'd5,
        TERR_SEC_DIGIT   = 3'd6,
        TERR_SEC_RANGE   = 3'd7
    } time_err_t;

    // finished record handed from the parser to the verdict stage
    typedef struct packed {
        logic [31:0]       record_number;
        logic              start_bad;
        logic              colon_bad;
        quality_t          quality;
        time_err_t         time_error;
        logic [SECS_W-1:0] total_seconds;
        logic [SECS_W-1:0] prev_seconds;
        logic              prev_valid;
        logic [63:0]       clock;
        logic [63:0]       prev_clock;
    } rec_snap_t;

    // result item
    typedef struct packed {
        logic [31:0]       record_number;
        logic              start_bad;
        logic              colon_bad;
        quality_t          quality_class;
        logic              quality_warn;
        time_err_t         time_error;
        logic [SECS_W-1:0] total_seconds;
        logic              checks_active;
        logic              clock_step_bad;
        logic [63:0]       clock_step;
        logic              time_step_bad;
    } verdict_t;

    function automatic quality_t classify_quality(input logic [7:0] b);
        quality_t q;
        priority if (b == CH_SPACE) q = QUAL_SPACE;
        else if (b == CH_DOT)       q = QUAL_DOT;
        else if (b == CH_STAR)      q = QUAL_STAR;
        else if (b == CH_HASH)      q = QUAL_HASH;
        else if (b == CH_QUEST)     q = QUAL_QUEST;
        else                        q = QUAL_INVALID;
        return q;
    endfunction

endpackage

// ===== src/tsc_if.sv =====
// interfaces: byte input channel and verdict output channel
`timescale 1ns / 1ps
interface tsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_start;

    modport source (output valid, output data_byte, output stream_start, input ready);
    modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

interface tsc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] record_number;
    logic        start_bad;
    logic        colon_bad;
    logic [2:0]  quality_class;
    logic        quality_warn;
    logic [2:0]  time_error;
    logic [26:0] total_seconds;
    logic        checks_active;
    logic        clock_step_bad;
    logic [63:0] clock_step;
    logic        time_step_bad;

    modport source (
        output valid, input ready,
        output record_number, output start_bad, output colon_bad,
        output quality_class, output quality_warn, output time_error,
        output total_seconds, output checks_active, output clock_step_bad,
        output clock_step, output time_step_bad
    );
    modport sink (
        input valid, output ready,
        input record_number, input start_bad, input colon_bad,
        input quality_class, input quality_warn, input time_error,
        input total_seconds, input checks_active, input clock_step_bad,
        input clock_step, input time_step_bad
    );
endinterface

// ===== src/tsc_parser.sv =====
// record parser: per-byte field accumulators, record count and previous-record state
`timescale 1ns / 1ps
module tsc_parser
    import tsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       stream_start,
    output logic       snap_valid,
    output rec_snap_t  snap
);

    logic [POS_W-1:0]  pos_reg;
    logic [31:0]       count_reg;
    logic [63:0]       clock_reg,        clock_next;
    logic [63:0]       prev_clock_reg;
    logic [9:0]        day_reg,          day_next;
    logic [6:0]        hour_reg,         hour_next;
    logic [6:0]        minute_reg,       minute_next;
    logic [6:0]        second_reg,       second_next;
    logic [3:0]        digits_ok_reg,    digits_ok_next;
    logic [1:0]        flags_reg,        flags_next;
    quality_t          quality_reg,      quality_next;
    logic [SECS_W-1:0] prev_seconds_reg;
    logic              prev_valid_reg;
    logic [SECS_W-1:0] secs_reg;
    time_err_t         err_reg;

    logic [POS_W-1:0]  pos_eff;
    logic              is_last;
    logic [31:0]       count_base;
    logic [63:0]       prev_clock_base;
    logic [SECS_W-1:0] prev_seconds_base;
    logic              prev_valid_base;
    logic              is_digit;
    logic [3:0]        digit_val;
    time_err_t         err_calc;
    logic [SECS_W-1:0] secs_calc;

    // stream start restarts position and stream history
    assign pos_eff           = stream_start ? POS_START : pos_reg;
    assign is_last           = (pos_eff == LAST_POS);
    assign count_base        = stream_start ? '0 : count_reg;
    assign prev_clock_base   = stream_start ? '0 : prev_clock_reg;
    assign prev_seconds_base = stream_start ? '0 : prev_seconds_reg;
    assign prev_valid_base   = stream_start ? 1'b0 : prev_valid_reg;

    assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign digit_val = 4'(data_byte - CH_ZERO);

    // field update for the byte at hand
    always_comb
    begin
        day_next       = day_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        digits_ok_next = digits_ok_reg;
        flags_next     = flags_reg;
        quality_next   = quality_reg;
        clock_next     = clock_reg;
        priority if (pos_eff == POS_START)
        begin
            day_next       = '0;
            hour_next      = '0;
            minute_next    = '0;
            second_next    = '0;
            digits_ok_next = '1;
            flags_next     = {1'b0, data_byte != START_BYTE};
            quality_next   = QUAL_SPACE;
            clock_next     = '0;
        end
        else if (pos_eff < POS_COLON0)
        begin
            if (is_digit)
                day_next = 10'({4'b0, day_reg} * 14'd10 + 14'(digit_val));
            else
                digits_ok_next[FD_DAY] = 1'b0;
        end
        else if (pos_eff == POS_COLON0 || pos_eff == POS_COLON1 || pos_eff == POS_COLON2)
        begin
            flags_next[1] = flags_reg[1] | (data_byte != CH_COLON);
        end
        else if (pos_eff == POS_HOUR || pos_eff == POS_HOUR + POS_W'(1))
        begin
            if (is_digit)
                hour_next = 7'({4'b0, hour_reg} * 11'd10 + 11'(digit_val));
            else
                digits_ok_next[FD_HOUR] = 1'b0;
        end
        else if (pos_eff == POS_MINUTE || pos_eff == POS_MINUTE + POS_W'(1))
        begin
            if (is_digit)
                minute_next = 7'({4'b0, minute_reg} * 11'd10 + 11'(digit_val));
            else
                digits_ok_next[FD_MINUTE] = 1'b0;
        end
        else if (pos_eff == POS_SECOND || pos_eff == POS_SECOND + POS_W'(1))
        begin
            if (is_digit)
                second_next = 7'({4'b0, second_reg} * 11'd10 + 11'(digit_val));
            else
                digits_ok_next[FD_SECOND] = 1'b0;
        end
        else if (pos_eff == POS_QUAL)
        begin
            quality_next = classify_quality(data_byte);
        end
        else
        begin
            clock_next = {clock_reg[55:0], data_byte};
        end
    end

    // time check from settled fields, first failing check wins
    always_comb
    begin
        priority if (!digits_ok_reg[FD_DAY])    err_calc = TERR_DAY_DIGIT;
        else if (!digits_ok_reg[FD_HOUR])       err_calc = TERR_HOUR_DIGIT;
        else if (hour_reg > HOUR_MAX)           err_calc = TERR_HOUR_RANGE;
        else if (!digits_ok_reg[FD_MINUTE])     err_calc = TERR_MIN_DIGIT;
        else if (minute_reg > MINSEC_MAX)       err_calc = TERR_MIN_RANGE;
        else if (!digits_ok_reg[FD_SECOND])     err_calc = TERR_SEC_DIGIT;
        else if (second_reg > MINSEC_MAX)       err_calc = TERR_SEC_RANGE;
        else                                    err_calc = TERR_OK;
    end

    // seconds since day zero, constant multiplies, zero on a time error
    always_comb
    begin
        secs_calc = SECS_W'(day_reg) * SECS_PER_DAY
                  + SECS_W'(hour_reg) * SECS_PER_HOUR
                  + SECS_W'(minute_reg) * SECS_PER_MIN
                  + SECS_W'(second_reg);
        if (err_calc != TERR_OK)
            secs_calc = '0;
    end

    // position, accumulators and stream history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= POS_START;
            count_reg        <= '0;
            clock_reg        <= '0;
            prev_clock_reg   <= '0;
            day_reg          <= '0;
            hour_reg         <= '0;
            minute_reg       <= '0;
            second_reg       <= '0;
            digits_ok_reg    <= '1;
            flags_reg        <= '0;
            quality_reg      <= QUAL_SPACE;
            prev_seconds_reg <= '0;
            prev_valid_reg   <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg       <= is_last ? POS_START : pos_eff + POS_W'(1);
            clock_reg     <= clock_next;
            day_reg       <= day_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            digits_ok_reg <= digits_ok_next;
            flags_reg     <= flags_next;
            quality_reg   <= quality_next;
            if (is_last)
            begin
                count_reg        <= count_base + 32'd1;
                prev_clock_reg   <= clock_next;
                prev_seconds_reg <= secs_reg;
                prev_valid_reg   <= (err_reg == TERR_OK);
            end
            else
            begin
                count_reg        <= count_base;
                prev_clock_reg   <= prev_clock_base;
                prev_seconds_reg <= prev_seconds_base;
                prev_valid_reg   <= prev_valid_base;
            end
        end
    end

    // time verdict captured once the second digits are in
    always_ff @(posedge clk)
    begin
        if (accept && pos_eff == POS_QUAL)
        begin
            secs_reg <= secs_calc;
            err_reg  <= err_calc;
        end
    end

    // finished record
    assign snap_valid = accept && is_last;

    always_comb
    begin
        snap.record_number = count_base + 32'd1;
        snap.start_bad     = flags_next[0];
        snap.colon_bad     = flags_next[1];
        snap.quality       = quality_next;
        snap.time_error    = err_reg;
        snap.total_seconds = secs_reg;
        snap.prev_seconds  = prev_seconds_base;
        snap.prev_valid    = prev_valid_base;
        snap.clock         = clock_next;
        snap.prev_clock    = prev_clock_base;
    end

    // checks
    a_pos_in_record: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("byte position past end of record");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid |=> pos_reg == POS_START)
        else $error("position did not wrap after last byte");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && stream_start && !is_last |=> count_reg == '0 && !prev_valid_reg)
        else $error("stream start did not clear history");

endmodule

// ===== src/tsc_verdict.sv =====
// verdict stage: record holding register, step checks and result register
`timescale 1ns / 1ps
module tsc_verdict
    import tsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        snap_valid,
    input  rec_snap_t   snap,
    output logic        snap_ready,
    input  logic        warn_degraded,
    input  logic [63:0] expected_clock_step,
    input  logic [15:0] warmup_records,
    output logic        out_valid,
    input  logic        out_ready,
    output verdict_t    out_item
);

    logic       s1_valid_reg;
    rec_snap_t  s1_reg;
    logic       out_valid_reg;
    verdict_t   out_reg, out_next;
    logic       s1_adv;

    // handshake between record register and result register
    assign s1_adv     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign snap_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (snap_valid)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_valid)
            s1_reg <= snap;
        if (s1_adv)
            out_reg <= out_next;
    end

    // step checks
    always_comb
    begin
        out_next.record_number  = s1_reg.record_number;
        out_next.start_bad      = s1_reg.start_bad;
        out_next.colon_bad      = s1_reg.colon_bad;
        out_next.quality_class  = s1_reg.quality;
        out_next.quality_warn   = warn_degraded
                                  && s1_reg.quality != QUAL_SPACE
                                  && s1_reg.quality != QUAL_INVALID;
        out_next.time_error     = s1_reg.time_error;
        out_next.total_seconds  = s1_reg.total_seconds;
        out_next.checks_active  = s1_reg.record_number > {16'b0, warmup_records};
        out_next.clock_step     = s1_reg.clock - s1_reg.prev_clock;
        out_next.clock_step_bad = out_next.checks_active
                                  && (out_next.clock_step != expected_clock_step);
        out_next.time_step_bad  = out_next.checks_active && s1_reg.prev_valid
                                  && (s1_reg.time_error != TERR_OK
                                      || {1'b0, s1_reg.total_seconds}
                                         != {1'b0, s1_reg.prev_seconds} + 28'd1);
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // checks
    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |-> !snap_ready)
        else $error("record accepted while both stages are blocked");

    a_secs_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.time_error != TERR_OK |-> out_reg.total_seconds == '0)
        else $error("seconds given for a bad time");

    a_steps_need_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.checks_active
        |-> !out_reg.clock_step_bad && !out_reg.time_step_bad)
        else $error("step flag raised during warm-up");

    a_warn_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.quality_warn
        |-> out_reg.quality_class != QUAL_SPACE && out_reg.quality_class != QUAL_INVALID)
        else $error("quality warning on a plain or invalid class");

endmodule

// ===== src/time_record_stream_checker_unit.sv =====
// top level: time record stream checker with configuration registers
//
// channel  | role   | handshake     | payload
// in_ch    | sink   | valid / ready | data_byte[7:0], stream_start
// out_ch   | source | valid / ready | record_number .. time_step_bad, one item per record
// cfg      | write  | cfg_we        | cfg_index[1:0], cfg_data[63:0]
//
// one byte is taken per clock unless stalled; results pass the record and result registers
// time fields are settled at the quality byte, step checks run in the verdict stage
// the input stalls whenever both verdict registers are full and the result is not taken
// rst_n clears position, counts, history and registers to their defaults
`timescale 1ns / 1ps
module time_record_stream_checker_unit
    import tsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tsc_in_if.sink      in_ch,
    tsc_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic        warn_degraded_reg;
    logic [63:0] expected_clock_step_reg;
    logic [15:0] warmup_records_reg;

    logic        accept;
    logic        snap_valid;
    logic        snap_ready;
    rec_snap_t   snap;
    verdict_t    out_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_degraded_reg       <= 1'b0;
            expected_clock_step_reg <= EXP_STEP_RESET;
            warmup_records_reg      <= WARMUP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WARN_DEGRADED:  warn_degraded_reg       <= cfg_data[0];
                CFG_EXPECTED_STEP:  expected_clock_step_reg <= cfg_data;
                CFG_WARMUP_RECORDS: warmup_records_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input handshake
    assign in_ch.ready = snap_ready;
    assign accept      = in_ch.valid && snap_ready;

    tsc_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (in_ch.data_byte),
        .stream_start (in_ch.stream_start),
        .snap_valid   (snap_valid),
        .snap         (snap)
    );

    tsc_verdict u_verdict (
        .clk                 (clk),
        .rst_n               (rst_n),
        .snap_valid          (snap_valid),
        .snap                (snap),
        .snap_ready          (snap_ready),
        .warn_degraded       (warn_degraded_reg),
        .expected_clock_step (expected_clock_step_reg),
        .warmup_records      (warmup_records_reg),
        .out_valid           (out_ch.valid),
        .out_ready           (out_ch.ready),
        .out_item            (out_item)
    );

    // result fields
    assign out_ch.record_number  = out_item.record_number;
    assign out_ch.start_bad      = out_item.start_bad;
    assign out_ch.colon_bad      = out_item.colon_bad;
    assign out_ch.quality_class  = out_item.quality_class;
    assign out_ch.quality_warn   = out_item.quality_warn;
    assign out_ch.time_error     = out_item.time_error;
    assign out_ch.total_seconds  = out_item.total_seconds;
    assign out_ch.checks_active  = out_item.checks_active;
    assign out_ch.clock_step_bad = out_item.clock_step_bad;
    assign out_ch.clock_step     = out_item.clock_step;
    assign out_ch.time_step_bad  = out_item.time_step_bad;

endmodule
